@@ hw/rtl/stpr_pkg.sv @@
// shared constants, types and a helper function for the scrolling tile page renderer
// no dependencies; imported by scrolling_tile_page_renderer, render_checker and testbench
`default_nettype none

package stpr_pkg;

   localparam int FIELD_ROWS     = 10;
   localparam int FIELD_COLS     = 18;
   localparam int TILE_COUNT     = 32;
   localparam int SCREEN_COLUMNS = 128;
   localparam int SCREEN_PAGES   = 8;
   localparam int MODULE         = 8;
   localparam int EDGES          = 2;

   localparam int CELLS         = FIELD_ROWS * FIELD_COLS;
   localparam int PATTERN_DEPTH = TILE_COUNT * MODULE;

   localparam int CELL_W  = $clog2(CELLS);
   localparam int PAT_W   = $clog2(PATTERN_DEPTH);
   localparam int TILE_W  = $clog2(TILE_COUNT);
   localparam int ROW_W   = $clog2(FIELD_ROWS);
   localparam int COL_W   = $clog2(FIELD_COLS);
   localparam int FINE_W  = $clog2(MODULE);
   localparam int SHIFT_W = FINE_W + 1;
   localparam int POS_W   = 8;
   localparam int SUM_W   = 7;

   typedef enum logic [1:0] {
      OP_CELL    = 2'd0,
      OP_PATTERN = 2'd1,
      OP_RENDER  = 2'd2
   } opcode_type;

   typedef enum logic {
      CSR_SCROLL_X = 1'b0,
      CSR_SCROLL_Y = 1'b1
   } csr_index_type;

   // remainder by a small constant, every multiple compared against the input in parallel
   function automatic logic [SUM_W-1:0] wrap_mod(input logic [SUM_W-1:0] v,
                                                 input int               m);
      logic [SUM_W-1:0] r;
      r = v;
      for (int k = 1; k < (1 << (SUM_W - 1)); k++) begin
         if ((k * m < (1 << SUM_W)) && (v >= SUM_W'(k * m))) begin
            r = v - SUM_W'(k * m);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stpr_ram.sv @@
// synchronous ram, one write port and two registered read ports
// depends on nothing but its parameters
`default_nettype none

module stpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read before write on the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

@@ hw/rtl/scrolling_tile_page_renderer.sv @@
// top level of the scrolling tile page renderer
// depends on stpr_pkg and stpr_ram
`default_nettype none

// Renders bytes of a 1-bit-per-pixel page display from a wrapped tile playfield and a
// tile pattern store. Every beat (cell write, pattern write or render) is taken at one
// per cycle while req_stall is low. A render goes through three register stages: the
// playfield memory read of the current and next tile row, the pattern memory read of
// both tile bytes, and the output register after the fine-Y merge. Both stores are
// dual-read memories, which is what lets one render finish per cycle when the output
// is not stalled. The stores are not cleared after reset and must be written before
// they are rendered from; scroll writes belong to idle time.
module scrolling_tile_page_renderer
   import stpr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [2:0] req_page,
   input  wire logic [6:0] req_column,
   input  wire logic [3:0] req_cell_row,
   input  wire logic [4:0] req_cell_col,
   input  wire logic [4:0] req_tile_index,
   input  wire logic [2:0] req_pattern_row,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_pixel_byte,
   output logic [2:0]      rsp_out_page,
   output logic [6:0]      rsp_out_column
);

   logic [7:0] scroll_x_ff, scroll_x_in;
   logic [7:0] scroll_y_ff, scroll_y_in;

   logic out_adv, s2_en, s1_en, accept;
   logic pf_we, pt_we, render_ok;

   logic [POS_W-1:0]  pos;
   logic [SUM_W-1:0]  col_sum, row_sum;
   logic [COL_W-1:0]  col;
   logic [ROW_W-1:0]  row, nrow;
   logic [CELL_W-1:0] rd_addr_a, rd_addr_b, wr_cell_addr;
   logic [PAT_W-1:0]  wr_pat_addr, pat_addr_a, pat_addr_b;
   logic [TILE_W-1:0] tile_a, tile_b;
   logic [7:0]        pat_a, pat_b, merged;

   logic              s1_v_ff, s1_v_in;
   logic [2:0]        s1_page_ff;
   logic [6:0]        s1_column_ff;
   logic [FINE_W-1:0] s1_fine_ff, s1_yfine_ff;

   logic              s2_v_ff, s2_v_in;
   logic [2:0]        s2_page_ff;
   logic [6:0]        s2_column_ff;
   logic [FINE_W-1:0] s2_yfine_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pixel_ff;
   logic [2:0] rsp_page_ff;
   logic [6:0] rsp_column_ff;

   // configuration
   always_comb begin
      scroll_x_in = scroll_x_ff;
      scroll_y_in = scroll_y_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SCROLL_X: scroll_x_in = csr_wdata;
            CSR_SCROLL_Y: scroll_y_in = csr_wdata;
            default:      scroll_x_in = scroll_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff <= '0;
         scroll_y_ff <= '0;
      end else begin
         scroll_x_ff <= scroll_x_in;
         scroll_y_ff <= scroll_y_in;
      end
   end

   // flow control, bubbles collapse toward the output
   always_comb begin
      out_adv   = !rsp_valid_ff || !rsp_stall;
      s2_en     = !s2_v_ff || out_adv;
      s1_en     = !s1_v_ff || s2_en;
      req_stall = !s1_en;
      accept    = req_valid && s1_en;
   end

   // beat decode
   always_comb begin
      pf_we     = 1'b0;
      pt_we     = 1'b0;
      render_ok = 1'b0;
      if (accept) begin
         case (opcode_type'(req_opcode))
            OP_CELL: pf_we = (req_cell_row < FIELD_ROWS) && (req_cell_col < FIELD_COLS)
                             && (req_tile_index < TILE_COUNT);
            OP_PATTERN: pt_we = (req_tile_index < TILE_COUNT);
            OP_RENDER: render_ok = (req_page < SCREEN_PAGES)
                                   && (req_column < SCREEN_COLUMNS);
            default: render_ok = 1'b0;
         endcase
      end
   end

   // playfield position of a render
   always_comb begin
      pos     = {1'b0, req_column} + POS_W'(scroll_x_ff[FINE_W-1:0]);
      col_sum = SUM_W'(scroll_x_ff[7:FINE_W]) + SUM_W'(EDGES / 2)
                + SUM_W'(pos[POS_W-1:FINE_W]);
      row_sum = SUM_W'(scroll_y_ff[7:FINE_W]) + SUM_W'(EDGES / 2) + SUM_W'(req_page);
      col     = COL_W'(wrap_mod(col_sum, FIELD_COLS));
      row     = ROW_W'(wrap_mod(row_sum, FIELD_ROWS));
      nrow    = (row == ROW_W'(FIELD_ROWS - 1)) ? '0 : row + 1'b1;
      rd_addr_a    = CELL_W'(row * FIELD_COLS) + CELL_W'(col);
      rd_addr_b    = CELL_W'(nrow * FIELD_COLS) + CELL_W'(col);
      wr_cell_addr = CELL_W'(req_cell_row * FIELD_COLS) + CELL_W'(req_cell_col);
      wr_pat_addr  = PAT_W'(req_tile_index * MODULE) + PAT_W'(req_pattern_row);
   end

   stpr_ram #(
      .WIDTH(TILE_W),
      .DEPTH(CELLS)
   ) u_playfield (
      .clock    (clock),
      .wr_en    (pf_we),
      .wr_addr  (wr_cell_addr),
      .wr_data  (req_tile_index[TILE_W-1:0]),
      .rd_en    (s1_en),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(tile_a),
      .rd_data_b(tile_b)
   );

   always_comb begin
      pat_addr_a = PAT_W'(tile_a * MODULE) + PAT_W'(s1_fine_ff);
      pat_addr_b = PAT_W'(tile_b * MODULE) + PAT_W'(s1_fine_ff);
   end

   stpr_ram #(
      .WIDTH(8),
      .DEPTH(PATTERN_DEPTH)
   ) u_pattern (
      .clock    (clock),
      .wr_en    (pt_we),
      .wr_addr  (wr_pat_addr),
      .wr_data  (req_data_byte),
      .rd_en    (s2_en),
      .rd_addr_a(pat_addr_a),
      .rd_addr_b(pat_addr_b),
      .rd_data_a(pat_a),
      .rd_data_b(pat_b)
   );

   // fine y merge of current and next tile row
   always_comb begin
      if (s2_yfine_ff == '0) begin
         merged = pat_a;
      end else begin
         merged = (pat_a >> s2_yfine_ff)
                  | (pat_b << (SHIFT_W'(MODULE) - SHIFT_W'(s2_yfine_ff)));
      end
   end

   always_comb begin
      s1_v_in      = s1_en ? render_ok : s1_v_ff;
      s2_v_in      = s2_en ? s1_v_ff : s2_v_ff;
      rsp_valid_in = out_adv ? s2_v_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_page_ff   <= req_page;
         s1_column_ff <= req_column;
         s1_fine_ff   <= pos[FINE_W-1:0];
         s1_yfine_ff  <= scroll_y_ff[FINE_W-1:0];
      end
      if (s2_en) begin
         s2_page_ff   <= s1_page_ff;
         s2_column_ff <= s1_column_ff;
         s2_yfine_ff  <= s1_yfine_ff;
      end
      if (out_adv) begin
         rsp_pixel_ff  <= merged;
         rsp_page_ff   <= s2_page_ff;
         rsp_column_ff <= s2_column_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_pixel_ff;
   assign rsp_out_page   = rsp_page_ff;
   assign rsp_out_column = rsp_column_ff;

   // assertions
   a_render_enters: assert property (@(posedge clock) disable iff (reset)
      render_ok |=> s1_v_ff)
      else $error("accepted render did not enter the pipeline");

   a_stage2_drains: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && out_adv) |=> rsp_valid)
      else $error("stage 2 render lost on its way to the output");

   a_stalled_render_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff && rsp_valid && rsp_stall) |-> req_stall)
      else $error("beat accepted while the pipeline is full");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!s1_v_ff && !s2_v_ff && !rsp_valid))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ bench/render_checker.sv @@
`timescale 1ns / 100ps
// render checker: watches the scroll register port and both channels of the renderer,
// keeps its own copy of the playfield, patterns and scroll, predicts each pixel byte
// and compares it with what comes out; depends on stpr_pkg
module render_checker
   import stpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [2:0] req_page,
   input  logic [6:0] req_column,
   input  logic [3:0] req_cell_row,
   input  logic [4:0] req_cell_col,
   input  logic [4:0] req_tile_index,
   input  logic [2:0] req_pattern_row,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_pixel_byte,
   input  logic [2:0] rsp_out_page,
   input  logic [6:0] rsp_out_column,
   output int         pending,
   output int         fail_count,
   output int         checked
);

   typedef struct {
      logic [7:0] pixels;
      logic [2:0] page;
      logic [6:0] column;
   } pixel_result_type;

   logic [4:0]       field_cells [CELLS];
   logic [7:0]       pattern_bytes [PATTERN_DEPTH];
   logic [7:0]       scroll_x_q;
   logic [7:0]       scroll_y_q;
   pixel_result_type pixels_due [$];

   function automatic logic [7:0] tile_byte(input int row, input int col, input int fine);
      return pattern_bytes[int'(field_cells[row * FIELD_COLS + col]) * MODULE + fine];
   endfunction

   function automatic logic [7:0] render_pixels(input logic [2:0] page,
                                                input logic [6:0] column);
      int         xfine;
      int         yfine;
      int         pos;
      int         col;
      int         row;
      int         fine;
      logic [7:0] cur;
      logic [7:0] nxt;
      xfine = int'(scroll_x_q[2:0]);
      yfine = int'(scroll_y_q[2:0]);
      pos   = int'(column) + xfine;
      col   = (int'(scroll_x_q[7:3]) + EDGES / 2 + pos / MODULE) % FIELD_COLS;
      row   = (int'(scroll_y_q[7:3]) + EDGES / 2 + int'(page)) % FIELD_ROWS;
      fine  = pos % MODULE;
      cur   = tile_byte(row, col, fine);
      if (yfine == 0) begin
         return cur;
      end
      nxt = tile_byte((row + 1) % FIELD_ROWS, col, fine);
      return (cur >> yfine) | (nxt << (MODULE - yfine));
   endfunction

   task automatic flag(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: mismatch: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type due;
      if (reset) begin
         pixels_due.delete();
         scroll_x_q = '0;
         scroll_y_q = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (pixels_due.size() == 0) begin
               flag($sformatf("beat with nothing expected: byte %02h page %0d column %0d",
                              rsp_pixel_byte, rsp_out_page, rsp_out_column));
            end else begin
               due = pixels_due.pop_front();
               if (rsp_pixel_byte !== due.pixels) begin
                  flag($sformatf("pixel_byte expected %02h got %02h (page %0d column %0d)",
                                 due.pixels, rsp_pixel_byte, due.page, due.column));
               end
               if (rsp_out_page !== due.page) begin
                  flag($sformatf("out_page expected %0d got %0d", due.page, rsp_out_page));
               end
               if (rsp_out_column !== due.column) begin
                  flag($sformatf("out_column expected %0d got %0d",
                                 due.column, rsp_out_column));
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_SCROLL_X) begin
               scroll_x_q = csr_wdata;
            end else begin
               scroll_y_q = csr_wdata;
            end
         end
         if (req_valid && !req_stall) begin
            case (req_opcode)
               OP_CELL: begin
                  if (int'(req_cell_row) < FIELD_ROWS && int'(req_cell_col) < FIELD_COLS &&
                      int'(req_tile_index) < TILE_COUNT) begin
                     field_cells[int'(req_cell_row) * FIELD_COLS + int'(req_cell_col)] =
                        req_tile_index;
                  end
               end
               OP_PATTERN: begin
                  if (int'(req_tile_index) < TILE_COUNT) begin
                     pattern_bytes[int'(req_tile_index) * MODULE + int'(req_pattern_row)] =
                        req_data_byte;
                  end
               end
               OP_RENDER: begin
                  if (int'(req_page) < SCREEN_PAGES && int'(req_column) < SCREEN_COLUMNS) begin
                     due.pixels = render_pixels(req_page, req_column);
                     due.page   = req_page;
                     due.column = req_column;
                     pixels_due.push_back(due);
                  end
               end
               default: begin
               end
            endcase
         end
      end
      pending = pixels_due.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// top of the renderer testbench: clock, reset, scroll settings, beat stimulus and verdict
// depends on stpr_pkg, scrolling_tile_page_renderer and render_checker
module testbench
   import stpr_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_PCT = 18;
   localparam int PHASES = 7;
   localparam int PHASE_BEATS = 60;

   typedef struct {
      logic [1:0] opcode;
      logic [2:0] page;
      logic [6:0] column;
      logic [3:0] cell_row;
      logic [4:0] cell_col;
      logic [4:0] tile_index;
      logic [2:0] pattern_row;
      logic [7:0] data_byte;
   } req_beat_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_index;
   logic [7:0] csr_wdata;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_opcode;
   logic [2:0] req_page;
   logic [6:0] req_column;
   logic [3:0] req_cell_row;
   logic [4:0] req_cell_col;
   logic [4:0] req_tile_index;
   logic [2:0] req_pattern_row;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_pixel_byte;
   logic [2:0] rsp_out_page;
   logic [6:0] rsp_out_column;

   int pending;
   int fail_count;
   int checked;
   bit steady;
   int op_counts [4];

   scrolling_tile_page_renderer uut (.*);
   render_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   function automatic req_beat_type random_fields();
      req_beat_type b;
      b.opcode      = 2'($urandom);
      b.page        = 3'($urandom);
      b.column      = 7'($urandom);
      b.cell_row    = 4'($urandom);
      b.cell_col    = 5'($urandom);
      b.tile_index  = 5'($urandom);
      b.pattern_row = 3'($urandom);
      b.data_byte   = 8'($urandom);
      return b;
   endfunction

   function automatic req_beat_type cell_beat(input int row, input int col, input int tile);
      req_beat_type b;
      b            = random_fields();
      b.opcode     = OP_CELL;
      b.cell_row   = 4'(row);
      b.cell_col   = 5'(col);
      b.tile_index = 5'(tile);
      return b;
   endfunction

   function automatic req_beat_type pattern_beat(input int tile, input int row,
                                                 input int data);
      req_beat_type b;
      b             = random_fields();
      b.opcode      = OP_PATTERN;
      b.tile_index  = 5'(tile);
      b.pattern_row = 3'(row);
      b.data_byte   = 8'(data);
      return b;
   endfunction

   function automatic req_beat_type render_beat(input int page, input int column);
      req_beat_type b;
      b        = random_fields();
      b.opcode = OP_RENDER;
      b.page   = 3'(page);
      b.column = 7'(column);
      return b;
   endfunction

   // mostly renders, with mostly in-range writes keeping the stores live
   function automatic req_beat_type mixed_beat();
      req_beat_type b;
      int           pick;
      b    = random_fields();
      pick = $urandom_range(99);
      if (pick < 55) begin
         b.opcode = OP_RENDER;
      end else if (pick < 75) begin
         b.opcode = OP_CELL;
         if ($urandom_range(99) < 85) begin
            b.cell_row = 4'($urandom_range(FIELD_ROWS - 1));
            b.cell_col = 5'($urandom_range(FIELD_COLS - 1));
         end
      end else if (pick < 95) begin
         b.opcode = OP_PATTERN;
      end else begin
         b.opcode = OP_UNUSED;
      end
      return b;
   endfunction

   // entered and left just after a falling edge
   task automatic send_beat(input req_beat_type b);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_opcode      <= b.opcode;
      req_page        <= b.page;
      req_column      <= b.column;
      req_cell_row    <= b.cell_row;
      req_cell_col    <= b.cell_col;
      req_tile_index  <= b.tile_index;
      req_pattern_row <= b.pattern_row;
      req_data_byte   <= b.data_byte;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      op_counts[b.opcode]++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic write_scroll(input logic [7:0] x, input logic [7:0] y);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SCROLL_X;
      csr_wdata <= x;
      @(negedge clock);
      csr_index <= CSR_SCROLL_Y;
      csr_wdata <= y;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic render_corners();
      send_beat(render_beat(0, 0));
      send_beat(render_beat(SCREEN_PAGES - 1, SCREEN_COLUMNS - 1));
      send_beat(render_beat(0, SCREEN_COLUMNS - 1));
      send_beat(render_beat(SCREEN_PAGES - 1, 0));
   endtask

   logic [7:0] phase_x [PHASES] = '{8'd0, 8'd143, 8'd7, 8'd136, 8'd0, 8'd8, 8'd0};
   logic [7:0] phase_y [PHASES] = '{8'd0, 8'd239, 8'd7, 8'd3, 8'd232, 8'd1, 8'd0};

   initial begin
      reset           = 1'b1;
      steady          = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_SCROLL_X;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_opcode      = OP_CELL;
      req_page        = '0;
      req_column      = '0;
      req_cell_row    = '0;
      req_cell_col    = '0;
      req_tile_index  = '0;
      req_pattern_row = '0;
      req_data_byte   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_scroll(8'd0, 8'd0);

      // fill every playfield cell and pattern byte before any render
      for (int r = 0; r < FIELD_ROWS; r++) begin
         for (int c = 0; c < FIELD_COLS; c++) begin
            send_beat(cell_beat(r, c, $urandom_range(TILE_COUNT - 1)));
         end
      end
      for (int t = 0; t < TILE_COUNT; t++) begin
         for (int k = 0; k < MODULE; k++) begin
            send_beat(pattern_beat(t, k, $urandom_range(255)));
         end
      end

      // directed: store extremes, ignored writes, corner renders, unused opcode
      send_beat(cell_beat(FIELD_ROWS - 1, FIELD_COLS - 1, TILE_COUNT - 1));
      send_beat(cell_beat(0, 0, 0));
      send_beat(pattern_beat(TILE_COUNT - 1, MODULE - 1, 8'hff));
      send_beat(pattern_beat(0, 0, 8'h00));
      send_beat(cell_beat(15, 31, 5));
      send_beat(cell_beat(FIELD_ROWS, 0, 7));
      send_beat(cell_beat(0, FIELD_COLS, 9));
      render_corners();
      send_beat(render_beat(3, 64));
      begin
         req_beat_type b;
         b        = random_fields();
         b.opcode = OP_UNUSED;
         send_beat(b);
      end
      send_beat(render_beat(4, 1));

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p >= PHASES - 2) begin
            phase_x[p] = 8'($urandom_range(143));
            phase_y[p] = 8'($urandom_range(239));
         end
         write_scroll(phase_x[p], phase_y[p]);
         steady = (p == 2);
         render_corners();
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if (p == 3 && i == PHASE_BEATS / 2) begin
               wait_idle();
            end
            send_beat(mixed_beat());
         end
      end
      steady = 1'b0;
      wait_idle();

      $display("sent %0d cell writes, %0d pattern writes, %0d renders, %0d unused beats",
               op_counts[OP_CELL], op_counts[OP_PATTERN], op_counts[OP_RENDER],
               op_counts[OP_UNUSED]);
      $display("%0d pixel bytes compared over %0d scroll settings, one at full rate",
               checked, PHASES + 1);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
